### hw/rtl/lrfs_pkg.sv
package lrfs_pkg;

  localparam int MaxSamples = 63;
  localparam int CntW = 6;

  localparam logic [2:0] CfgSpacing = 3'd0;
  localparam logic [2:0] CfgHTol    = 3'd1;
  localparam logic [2:0] CfgRAbs    = 3'd2;
  localparam logic [2:0] CfgRRel    = 3'd3;
  localparam logic [2:0] CfgClear   = 3'd4;

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeClear  = 2'd1;
  localparam logic [1:0] ModeGround = 2'd2;
  localparam logic [1:0] ModeHit    = 2'd3;

  typedef struct packed {
    logic signed [23:0] origin_x_mm;
    logic signed [23:0] origin_y_mm;
    logic signed [23:0] origin_z_mm;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        range_mm;
    logic               range_invalid;
  } ray_t;

  typedef struct packed {
    logic signed [23:0] point_x_mm;
    logic signed [23:0] point_y_mm;
    logic signed [23:0] point_z_mm;
    logic               height_valid;
    logic               cell_occupied;
    logic               last_of_ray;
  } sample_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic [11:0] spacing;
    logic [15:0] h_tol;
    logic [15:0] r_abs;
    logic [15:0] r_rel;
    logic [15:0] clear;
  } regs_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch ray, start classify
    logic gstep;     // advance ground test pipeline
    logic decide;    // set mode and limit
    logic calc;      // compute sample at cur_d
    logic advance;   // cur_d += spacing
    logic hit_pt;    // compute hit sample
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       in_range;  // 2*cur_d <= lim2
    logic [1:0] mode;
  } dp_stat_t;

  function automatic logic signed [23:0] rnd_sat(input logic signed [23:0] o,
                                                 input logic signed [33:0] p);
    logic [33:0] a;
    logic signed [35:0] q;
    logic signed [35:0] s;
    begin
      a = p[33] ? 34'(-p) : p;
      a = (a + 34'd16384) >> 15;
      q = p[33] ? -36'(a) : 36'(a);
      s = 36'(o) + q;
      if (s > 36'sd8388607) rnd_sat = 24'sh7fffff;
      else if (s < -36'sd8388608) rnd_sat = 24'sh800000;
      else rnd_sat = s[23:0];
    end
  endfunction

endpackage

### hw/rtl/lrfs_if.sv
interface lrfs_ray_if;
  import lrfs_pkg::*;
  logic valid;
  logic ready;
  ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrfs_sample_if;
  import lrfs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lrfs_cfg_if;
  import lrfs_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lrfs_datapath.sv
module lrfs_datapath import lrfs_pkg::*; (
  input  logic     clk,
  input  ray_t     ray,
  input  regs_t    regs,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output sample_t  smp
);

  ray_t r;
  logic [11:0] sp;
  logic [17:0] cur_d;
  logic signed [19:0] lim2;
  logic [1:0] mode;
  logic hv;
  logic occ;

  // ground test products, registered
  logic signed [40:0] hnum;       // sz*2^15 + r*dz
  logic [32:0] rn;                // r * n
  logic [32:0] tan;               // abs_tol * n
  logic [40:0] szrel;             // sz * rel
  logic elig;

  logic [16:0] n_dz;
  logic signed [33:0] px, py, pz;
  logic [15:0] d16;
  logic signed [56:0] rn16, sz31, diff, tr, ta, tmax;
  logic signed [56:0] adiff;
  logic signed [40:0] ahn;
  logic g_h, g_r;

  assign n_dz = 17'(-$signed({r.dir_z[15], r.dir_z}));
  assign d16  = cur_d[15:0];

  always_comb begin
    ahn   = hnum[40] ? -hnum : hnum;
    g_h   = ahn <= $signed({10'd0, regs.h_tol, 15'd0});
    rn16  = $signed({8'd0, rn, 16'd0});
    sz31  = $signed(57'(r.origin_z_mm)) <<< 31;
    diff  = rn16 - sz31;
    adiff = diff[56] ? -diff : diff;
    ta    = $signed({8'd0, tan, 16'd0});
    tr    = $signed({1'b0, szrel, 15'd0});
    tmax  = (ta > tr) ? ta : tr;
    g_r   = adiff <= tmax;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r     <= ray;
      sp    <= (regs.spacing == 12'd0) ? 12'd1 : regs.spacing;
      cur_d <= 18'((regs.spacing == 12'd0) ? 12'd1 : regs.spacing);
    end
    if (cmd.gstep) begin
      hnum  <= 41'($signed(r.origin_z_mm)) * 41'sd32768
               + 41'($signed({1'b0, r.range_mm}) * r.dir_z);
      rn    <= 33'(r.range_mm) * 33'(n_dz);
      tan   <= 33'(regs.r_abs) * 33'(n_dz);
      szrel <= 41'(r.origin_z_mm[22:0]) * 41'(regs.r_rel);
      elig  <= !r.origin_z_mm[23] && (r.origin_z_mm != 24'd0) && r.dir_z[15];
    end
    if (cmd.decide) begin
      if (r.range_invalid) begin
        mode <= ModeClear;
        lim2 <= (regs.clear == 16'd0) ? -20'sd1 : $signed({3'd0, regs.clear, 1'b0});
      end else if (r.range_mm == 16'd0) begin
        mode <= ModeIdle;
        lim2 <= -20'sd1;
      end else if (elig && (g_h || g_r)) begin
        mode <= ModeGround;
        lim2 <= $signed({3'd0, r.range_mm, 1'b0});
      end else begin
        mode <= ModeHit;
        lim2 <= $signed({3'd0, r.range_mm, 1'b0}) - $signed({8'd0, sp});
      end
    end
    if (cmd.advance) cur_d <= cur_d + 18'(sp);
    if (cmd.calc) begin
      px  <= $signed({1'b0, d16}) * r.dir_x;
      py  <= $signed({1'b0, d16}) * r.dir_y;
      pz  <= $signed({1'b0, d16}) * r.dir_z;
      hv  <= (mode == ModeGround);
      occ <= 1'b0;
    end
    if (cmd.hit_pt) begin
      px  <= $signed({1'b0, r.range_mm}) * r.dir_x;
      py  <= $signed({1'b0, r.range_mm}) * r.dir_y;
      pz  <= $signed({1'b0, r.range_mm}) * r.dir_z;
      hv  <= 1'b1;
      occ <= 1'b1;
    end
  end

  always_comb begin
    smp.point_x_mm    = rnd_sat(r.origin_x_mm, px);
    smp.point_y_mm    = rnd_sat(r.origin_y_mm, py);
    smp.point_z_mm    = hv ? rnd_sat(r.origin_z_mm, pz) : 24'sd0;
    smp.height_valid  = hv;
    smp.cell_occupied = occ;
    smp.last_of_ray   = 1'b0;
  end

  assign stat.in_range = $signed({1'b0, cur_d, 1'b0}) <= 20'(lim2) && !lim2[19];
  assign stat.mode     = mode;

endmodule

### hw/rtl/lrfs_ctrl.sv
module lrfs_ctrl import lrfs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] SIdle = 3'd0, SG = 3'd1, SDec = 3'd2, SChk = 3'd3,
                         SOut = 3'd4, SHit = 3'd5;

  logic [2:0] state;
  logic [CntW-1:0] cnt;
  logic last_next;

  // free sample can be produced if in range and under cap
  logic more;
  assign more = stat.in_range && (cnt < CntW'(MaxSamples));

  assign in_ready = (state == SIdle);

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.gstep   = (state == SG);
    cmd.decide  = (state == SDec);
    cmd.calc    = (state == SChk) && more;
    cmd.advance = cmd.calc;
    cmd.hit_pt  = (state == SChk) && !more && (stat.mode == ModeHit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        SIdle: if (cmd.load) state <= SG;
        SG: state <= SDec;
        SDec: begin
          cnt <= '0;
          state <= SChk;
        end
        SChk: begin
          if (more) begin
            cnt <= cnt + 1'b1;
            out_valid <= 1'b1;
            state <= SOut;
          end else if (stat.mode == ModeHit) begin
            out_valid <= 1'b1;
            state <= SHit;
          end else state <= SIdle;
        end
        SOut: if (out_ready) begin
          out_valid <= 1'b0;
          state <= SChk;
        end
        SHit: if (out_ready) begin
          out_valid <= 1'b0;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

  // last: hit, or free sample whose successor will not exist
  always_comb begin
    last_next = 1'b0;
    if (state == SHit) last_next = 1'b1;
    else if (state == SOut)
      last_next = (stat.mode != ModeHit) &&
                  (!stat.in_range || cnt >= CntW'(MaxSamples));
  end
  assign out_last = last_next;

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == SOut || state == SHit)) else $error("valid out of place");
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while busy");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(MaxSamples)) else $error("cap exceeded");

endmodule

### hw/rtl/lidar_ray_free_space_sampler_top.sv
// An accepted ray passes a ground-test step and a decide step before its first sample check.
// Each free sample is computed, then held until the output handshake; a hit sample, if any, comes last.
// Rays are handled sequentially: a new ray is accepted only once the current ray is finished.
// Synchronous active-high rst restores register defaults and idles the block.
module lidar_ray_free_space_sampler_top import lrfs_pkg::*; (
  input logic clk,
  input logic rst,
  lrfs_ray_if.sink      ray,
  lrfs_sample_if.source sample,
  lrfs_cfg_if.sink      cfg
);

  regs_t regs;
  dp_cmd_t cmd;
  dp_stat_t stat;
  sample_t smp;
  logic last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.spacing <= 12'd50;
      regs.h_tol   <= 16'd50;
      regs.r_abs   <= 16'd60;
      regs.r_rel   <= 16'd7864;
      regs.clear   <= 16'd4000;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CfgSpacing: regs.spacing <= cfg.data.data[11:0];
        CfgHTol:    regs.h_tol   <= cfg.data.data;
        CfgRAbs:    regs.r_abs   <= cfg.data.data;
        CfgRRel:    regs.r_rel   <= cfg.data.data;
        CfgClear:   regs.clear   <= cfg.data.data;
        default: ;
      endcase
    end
  end

  lrfs_datapath u_dp (
    .clk(clk), .ray(ray.data), .regs(regs), .cmd(cmd), .stat(stat), .smp(smp)
  );

  lrfs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(ray.valid), .in_ready(ray.ready),
    .out_valid(sample.valid), .out_ready(sample.ready), .out_last(last),
    .stat(stat), .cmd(cmd)
  );

  always_comb begin
    sample.data = smp;
    sample.data.last_of_ray = last;
  end

endmodule
